// ===== src/kcd_pkg.sv =====
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants of the key click / double / long-press detector.
// ----------------------------------------------------------------------------
package kcd_pkg;

	localparam int KeyW   = 4;
	localparam int TimeW  = 32;
	localparam int RegW   = 16;
	localparam int CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_DOUBLE_GAP = 1'b1;

	localparam logic [RegW-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [RegW-1:0] DOUBLE_GAP_RST = 16'd300;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef struct packed {
		logic [TimeW-1:0] press_time;
		logic [TimeW-1:0] release_time;
		logic [1:0]       click_count;
		logic             long_fired;
		logic             prev_level;
	} key_state_t;

	typedef struct packed {
		logic [RegW-1:0] long_press_ms;
		logic [RegW-1:0] double_gap_ms;
	} timing_cfg_t;

endpackage

// ===== src/kcd_sample_if.sv =====
// ----------------------------------------------------------------------------
// kcd_sample_if
// Valid/ready channel carrying one debounced key sample.
// ----------------------------------------------------------------------------
interface kcd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [kcd_pkg::KeyW-1:0]      key_index;
	logic                          pressed;
	logic [kcd_pkg::TimeW-1:0]     now_ms;

	modport source (output valid, key_index, pressed, now_ms, input ready);
	modport sink   (input valid, key_index, pressed, now_ms, output ready);
endinterface

// ===== src/kcd_event_if.sv =====
// ----------------------------------------------------------------------------
// kcd_event_if
// Valid/ready channel carrying one key event result.
// ----------------------------------------------------------------------------
interface kcd_event_if;
	logic                     valid;
	logic                     ready;
	logic [kcd_pkg::KeyW-1:0] key_id;
	logic [1:0]               event_code;

	modport source (output valid, key_id, event_code, input ready);
	modport sink   (input valid, key_id, event_code, output ready);
endinterface

// ===== src/kcd_keys.sv =====
// ----------------------------------------------------------------------------
// kcd_keys
// Per-key state registers: one combinational read port, one write port.
// ----------------------------------------------------------------------------
module kcd_keys #(
	parameter int NUM_KEYS = 10,
	parameter int IdxW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IdxW-1:0]     rd_idx,
	output kcd_pkg::key_state_t rd_state,
	input  logic                wr_en,
	input  logic [IdxW-1:0]     wr_idx,
	input  kcd_pkg::key_state_t wr_state
);

	kcd_pkg::key_state_t keys_q [NUM_KEYS];

	assign rd_state = keys_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				keys_q[k] <= '0;
			end
		end else if (wr_en) begin
			keys_q[wr_idx] <= wr_state;
		end
	end

endmodule

// ===== src/kcd_eval.sv =====
// ----------------------------------------------------------------------------
// kcd_eval
// Edge classification and event decision for one key sample.
// ----------------------------------------------------------------------------
module kcd_eval (
	input  kcd_pkg::key_state_t  cur,
	input  logic                 pressed,
	input  logic [kcd_pkg::TimeW-1:0] now_ms,
	input  kcd_pkg::timing_cfg_t cfg,
	output kcd_pkg::key_state_t  nxt,
	output kcd_pkg::event_t      ev
);

	logic [kcd_pkg::TimeW-1:0] held;
	logic [kcd_pkg::TimeW-1:0] idle;
	logic                      long_due;
	logic                      gap_over;

	// time differences wrap modulo 2^32
	assign held     = now_ms - cur.press_time;
	assign idle     = now_ms - cur.release_time;
	assign long_due = held >= {{(kcd_pkg::TimeW-kcd_pkg::RegW){1'b0}}, cfg.long_press_ms};
	assign gap_over = idle > {{(kcd_pkg::TimeW-kcd_pkg::RegW){1'b0}}, cfg.double_gap_ms};

	always_comb begin
		nxt            = cur;
		ev             = kcd_pkg::EV_NONE;
		nxt.prev_level = pressed;
		case ({pressed, cur.prev_level})
			2'b10: begin
				nxt.press_time = now_ms;
				nxt.long_fired = 1'b0;
			end
			2'b11: begin
				if (long_due && !cur.long_fired) begin
					ev              = kcd_pkg::EV_LONG;
					nxt.long_fired  = 1'b1;
					nxt.click_count = 2'd0;
				end
			end
			2'b01: begin
				nxt.release_time = now_ms;
				if (!cur.long_fired && cur.click_count != 2'd2 && cur.click_count != 2'd3) begin
					nxt.click_count = cur.click_count + 2'd1;
				end
			end
			default: begin
				// idle: resolve pending clicks
				if (cur.click_count == 2'd1 && gap_over) begin
					ev              = kcd_pkg::EV_SINGLE;
					nxt.click_count = 2'd0;
				end else if (cur.click_count == 2'd2 && !gap_over) begin
					ev              = kcd_pkg::EV_DOUBLE;
					nxt.click_count = 2'd0;
				end
			end
		endcase
	end

endmodule

// ===== src/key_click_double_long_detector.sv =====
// ----------------------------------------------------------------------------
// key_click_double_long_detector
// Click, double-click and long-press detection over debounced key samples.
// ----------------------------------------------------------------------------
// One sample is taken per cycle unless the output stalls, and each sample gives
// exactly one result, from the output register. The sample is registered, the
// addressed key's state is read, updated and written back in the same cycle,
// and the event lands in an output register; so a sample of the same key in
// the very next cycle sees the updated state. Key indexes at or above
// NUM_KEYS return event code 0 and touch no state. Timing registers are
// written through cfg_we/cfg_index/cfg_wdata and should change only while idle.
// ----------------------------------------------------------------------------
module key_click_double_long_detector #(
	parameter int NUM_KEYS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	kcd_sample_if.sink                   samples,
	kcd_event_if.source                  events,
	input  logic                         cfg_we,
	input  logic [kcd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kcd_pkg::RegW-1:0]     cfg_wdata
);

	localparam int IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kcd_pkg::timing_cfg_t cfg_q;

	logic                      valid_s1;
	logic [kcd_pkg::KeyW-1:0]  key_s1;
	logic                      pressed_s1;
	logic [kcd_pkg::TimeW-1:0] now_s1;

	logic                      out_valid_q;
	logic [kcd_pkg::KeyW-1:0]  key_q;
	kcd_pkg::event_t           code_q;

	logic                      advance;
	logic                      key_ok;
	kcd_pkg::key_state_t       cur_state;
	kcd_pkg::key_state_t       nxt_state;
	kcd_pkg::event_t           ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms <= kcd_pkg::LONG_PRESS_RST;
			cfg_q.double_gap_ms <= kcd_pkg::DOUBLE_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kcd_pkg::REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_wdata;
				kcd_pkg::REG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance       = !out_valid_q || events.ready;
	assign samples.ready = !valid_s1 || advance;
	assign key_ok        = {1'b0, key_s1} < (kcd_pkg::KeyW+1)'(NUM_KEYS);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			key_s1     <= samples.key_index;
			pressed_s1 <= samples.pressed;
			now_s1     <= samples.now_ms;
		end
	end

	kcd_keys #(
		.NUM_KEYS (NUM_KEYS),
		.IdxW     (IdxW)
	) u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (key_s1[IdxW-1:0]),
		.rd_state (cur_state),
		.wr_en    (valid_s1 && advance && key_ok),
		.wr_idx   (key_s1[IdxW-1:0]),
		.wr_state (nxt_state)
	);

	kcd_eval u_eval (
		.cur     (cur_state),
		.pressed (pressed_s1),
		.now_ms  (now_s1),
		.cfg     (cfg_q),
		.nxt     (nxt_state),
		.ev      (ev)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			key_q  <= key_s1;
			code_q <= key_ok ? ev : kcd_pkg::EV_NONE;
		end
	end

	assign events.valid      = out_valid_q;
	assign events.key_id     = key_q;
	assign events.event_code = code_q;

endmodule

// ===== src/kcd_checker.sv =====
// ----------------------------------------------------------------------------
// kcd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module kcd_checker #(
	parameter int NUM_KEYS = 10
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_valid,
	input logic                     s_ready,
	input logic                     e_valid,
	input logic                     e_ready,
	input logic [kcd_pkg::KeyW-1:0] e_key_id,
	input logic [1:0]               e_event_code
);

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!e_valid |-> s_ready)
		else $error("input stalled with output empty");

	// unknown keys never report an event
	a_bad_key_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && ({1'b0, e_key_id} >= (kcd_pkg::KeyW+1)'(NUM_KEYS)) |->
		e_event_code == kcd_pkg::EV_NONE)
		else $error("event reported for key out of range");

	// a result can only appear after some input transfer
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(e_valid) |-> $past(s_valid && s_ready, 2) || $past(s_valid && s_ready, 1)
		|| $past(e_valid, 2))
		else $error("result without a transfer in");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && !e_ready |=> e_valid && $stable(e_key_id) && $stable(e_event_code))
		else $error("stalled result changed");

endmodule

bind key_click_double_long_detector kcd_checker #(
	.NUM_KEYS (NUM_KEYS)
) u_kcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_valid      (samples.valid),
	.s_ready      (samples.ready),
	.e_valid      (events.valid),
	.e_ready      (events.ready),
	.e_key_id     (events.key_id),
	.e_event_code (events.event_code)
);
